>>> design/upd_pkg.sv
// upd_pkg: shared types and constants of the url percent decoder
// queue entry layout, character codes and status codes; no dependencies
package upd_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HEX  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [15:0] CAP_RESET = 16'd256;

  // work for the back part: up to two bytes and an optional status result
  typedef struct packed {
    logic       b0_vld;
    logic [7:0] b0;
    logic       b1_vld;
    logic [7:0] b1;
    logic       term;
    logic [1:0] st;
  } upd_entry_t;

endpackage

>>> design/upd_front.sv
// upd_front: accepts input bytes, keeps escape state and the byte count
// and pushes result work into the queue; depends on upd_pkg
module upd_front import upd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic [7:0]  in_char,
  input  logic        q_full,
  output logic        in_ready,
  output logic        push,
  output upd_entry_t  push_entry
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  logic [15:0] out_capacity;
  logic [1:0]  escape_phase, escape_phase_next;
  logic [7:0]  held_digit, held_digit_next;
  logic [15:0] written_count, written_count_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic [16:0] cap17;
  logic        room1, room2;
  logic        hi_ok, lo_ok;
  logic [3:0]  hi_val, lo_val;
  upd_entry_t  entry;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_value = {1'b1, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA;
        hex_value = {1'b1, d[3:0] + HEX_TEN};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA;
        hex_value = {1'b1, d[3:0] + HEX_TEN};
      end else begin
        hex_value = 5'd0;
      end
    end
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    plain = (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign cap17    = {1'b0, out_capacity};
  assign room1    = ({1'b0, written_count} + 17'd1) < cap17;
  assign room2    = ({1'b0, written_count} + 17'd2) < cap17;
  assign {hi_ok, hi_val} = hex_value(held_digit);
  assign {lo_ok, lo_val} = hex_value(in_char);

  always_comb begin
    escape_phase_next  = escape_phase;
    held_digit_next    = held_digit;
    written_count_next = written_count;
    discarding_next    = discarding;
    entry              = '0;
    if (in_char == CH_NUL) begin
      entry.term = 1'b1;
      if (discarding) begin
        entry.st = escape_phase;
      end else if (escape_phase == PH_PCT) begin
        entry.b0_vld = 1'b1;
        entry.b0     = CH_PERCENT;
      end else if (escape_phase == PH_HELD) begin
        entry.b0_vld = 1'b1;
        entry.b0     = CH_PERCENT;
        if (!room2) begin
          entry.st = ST_OVERFLOW;
        end else begin
          entry.b1_vld = 1'b1;
          entry.b1     = plain(held_digit);
        end
      end else if (out_capacity == 16'd0) begin
        entry.st = ST_OVERFLOW;
      end
      escape_phase_next  = PH_IDLE;
      held_digit_next    = 8'd0;
      written_count_next = 16'd0;
      discarding_next    = 1'b0;
    end else if (!discarding) begin
      if (escape_phase == PH_PCT) begin
        held_digit_next   = in_char;
        escape_phase_next = PH_HELD;
      end else if (escape_phase == PH_HELD) begin
        held_digit_next = 8'd0;
        if (!hi_ok || !lo_ok) begin
          discarding_next   = 1'b1;
          escape_phase_next = ST_BAD_HEX;
        end else begin
          escape_phase_next  = PH_IDLE;
          entry.b0_vld       = 1'b1;
          entry.b0           = {hi_val, lo_val};
          written_count_next = written_count + 16'd1;
        end
      end else if (!room1) begin
        discarding_next   = 1'b1;
        escape_phase_next = ST_OVERFLOW;
        held_digit_next   = 8'd0;
      end else if (in_char == CH_PERCENT) begin
        escape_phase_next = PH_PCT;
      end else begin
        entry.b0_vld       = 1'b1;
        entry.b0           = plain(in_char);
        written_count_next = written_count + 16'd1;
      end
    end
  end

  assign push       = accept && (entry.b0_vld || entry.term);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity  <= CAP_RESET;
      escape_phase  <= PH_IDLE;
      held_digit    <= 8'd0;
      written_count <= 16'd0;
      discarding    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_capacity <= cfg_data;
      end
      if (accept) begin
        escape_phase  <= escape_phase_next;
        held_digit    <= held_digit_next;
        written_count <= written_count_next;
        discarding    <= discarding_next;
      end
    end
  end

  a_discard_status: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (escape_phase == ST_BAD_HEX || escape_phase == ST_OVERFLOW))
    else $error("discarding without a stored error status");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (escape_phase == PH_IDLE && !discarding) |-> held_digit == 8'd0)
    else $error("held digit left over outside an escape");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_char == CH_NUL) |=>
      (escape_phase == PH_IDLE && !discarding && written_count == 16'd0))
    else $error("terminator did not return state to start of string");

  a_term_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && in_char == CH_NUL) |-> push)
    else $error("terminator lost its status transaction");

endmodule

>>> design/upd_queue.sv
// upd_queue: short fifo of result work between front and back parts
// depends on upd_pkg for the entry type
module upd_queue import upd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  upd_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output upd_entry_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  upd_entry_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("write into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("read from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule

>>> design/upd_back.sv
// upd_back: expands queued work into result transactions, one a cycle
// unless out_ready stalls, via a registered output; depends on upd_pkg
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  upd_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_end,
  output logic [1:0] out_status
);

  logic       done0, done1;
  logic       r0, r1, r2;
  logic       load;
  logic [7:0] sel_char;
  logic       sel_end;
  logic [1:0] sel_status;

  assign r0   = head.b0_vld && !done0;
  assign r1   = head.b1_vld && !done1;
  assign r2   = head.term;
  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    sel_char   = 8'd0;
    sel_end    = 1'b0;
    sel_status = ST_OK;
    pop        = 1'b0;
    if (r0) begin
      sel_char = head.b0;
      pop      = load && !r1 && !r2;
    end else if (r1) begin
      sel_char = head.b1;
      pop      = load && !r2;
    end else begin
      sel_end    = 1'b1;
      sel_status = head.st;
      pop        = load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done0     <= 1'b0;
      done1     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        done0 <= 1'b0;
        done1 <= 1'b0;
      end else if (load) begin
        if (r0) begin
          done0 <= 1'b1;
        end else begin
          done1 <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char   <= sel_char;
      out_end    <= sel_end;
      out_status <= sel_status;
    end
  end

  a_status_only_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_end) |-> (out_status == ST_OK))
    else $error("status on a byte transaction");

  a_end_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (out_char == 8'd0))
    else $error("non-zero byte on the status transaction");

  a_progress_needs_head: assert property (@(posedge clk) disable iff (rst)
    (done0 || done1) |-> head_valid)
    else $error("partial progress kept with no entry at the head");

endmodule

>>> design/url_percent_decoder_top.sv
// url_percent_decoder_top: top level of the url percent decoder
// instantiates upd_front, upd_queue and upd_back; depends on upd_pkg
//
// input stream s_axis_*: one string byte per transaction, zero ends the string.
// output stream m_axis_*: decoded bytes, then one status transaction per string
//   with tlast high, tdata zero and tuser holding 0 ok, 1 bad hex, 2 overflow.
// cfg_*: writes the output capacity (bytes including terminator), reset 256;
//   the user must write it only while the block is idle; the block does not
//   enforce this. cfg_ready is always high.
// the front accepts one byte a cycle while the queue is not full and decodes
// it in that cycle; work goes through a QUEUE_DEPTH entry queue to the back,
// which drives a registered output: a result passes the queue entry and then
// the output register. throughput is one input a cycle while the queue is
// not full; the back emits one result a cycle unless m_axis_tready stalls it,
// so a terminator that flushes a pending escape yields up to three results.
// when m_axis_tready is low the output register holds, the queue fills and
// s_axis_tready drops once it is full. reset (rst, synchronous) empties the
// queue, clears the escape state and sets the capacity back to 256.
module url_percent_decoder_top import upd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,       // out_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_char
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // status
);

  logic       push, pop, q_full, head_valid;
  upd_entry_t push_entry, head;

  assign cfg_ready = 1'b1;

  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_char    (s_axis_tdata),
    .q_full     (q_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  upd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_end    (m_axis_tlast),
    .out_status (m_axis_tuser)
  );

endmodule
